### src/greedy_capacity_assignment_unit_assert.svh
// Assertion macros for the greedy capacity assignment unit RTL.
// ASSERT_AT: property sampled at the rising clock edge, quiet during reset.
// ASSERT_NEVER: a condition that must never hold at a rising clock edge.
`ifndef GREEDY_CAPACITY_ASSIGNMENT_UNIT_ASSERT_SVH
`define GREEDY_CAPACITY_ASSIGNMENT_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

### src/gca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gca_pkg;
	localparam int MODE_W   = 2;
	localparam int ISLOT_W  = 6;
	localparam int BSLOT_W  = 7;
	localparam int COUNT_W  = 7;
	localparam int CFG_IDX_W = 1;
	localparam int SUM_W    = 27;
	localparam int OUT_W    = 26;

	localparam logic [MODE_W-1:0] MODE_LOAD_ITEM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_BOX  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_COUNT  = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_BSCAN,
		ST_ISCAN,
		ST_DONE
	} gca_state_t;
endpackage
`default_nettype wire

### src/gca_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gca_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/greedy_capacity_assignment_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake            Word
// in       sink       in_valid / in_stall  mode, slots, amounts, exclusion range
// out      source     out_valid/out_stall  total_value
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// For a query, each box round walks the capacity memory for the smallest open
// box and then the item memory for the best fit, one entry a cycle through a
// single read port and one shared comparator.
// arst_n clears the sequencer, flags, counts and the output valid flag; the
// tables hold garbage until written. in_stall stays high through a query and
// while its result still waits behind a stalled output. cfg_ready is always high.
module greedy_capacity_assignment_unit
	import gca_pkg::*;
#(
	parameter int MAX_ITEMS   = 64,
	parameter int MAX_BOXES   = 64,
	parameter int AMOUNT_BITS = 20
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [COUNT_W-1:0]     cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [MODE_W-1:0]      mode,
	input  wire logic [ISLOT_W-1:0]     item_slot,
	input  wire logic [AMOUNT_BITS-1:0] item_weight_in,
	input  wire logic [AMOUNT_BITS-1:0] item_value_in,
	input  wire logic [BSLOT_W-1:0]     box_slot,
	input  wire logic [AMOUNT_BITS-1:0] box_capacity_in,
	input  wire logic [BSLOT_W-1:0]     exclude_low,
	input  wire logic [BSLOT_W-1:0]     exclude_high,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [OUT_W-1:0]            total_value
);
	localparam int IA = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int BA = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int MAXN = (MAX_ITEMS > MAX_BOXES) ? MAX_ITEMS : MAX_BOXES;
	localparam int CW = $clog2(MAXN + 1);
	localparam int AB = AMOUNT_BITS;

	gca_state_t state_q, state_d;

	logic [COUNT_W-1:0] item_count_q, box_count_q;
	logic [BSLOT_W-1:0] lo_q, hi_q;
	logic [CW-1:0]      nitems_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_s1;
	logic               vld_s1;
	logic               found_q;
	logic [AB-1:0]      best_q;     // smallest capacity, then best value
	logic [AB-1:0]      cap_q;      // capacity of the box being filled
	logic [BA-1:0]      box_pick_q;
	logic [IA-1:0]      item_pick_q;
	logic [MAX_BOXES-1:0] box_done_q;
	logic [MAX_ITEMS-1:0] item_taken_q;
	logic [SUM_W-1:0]   sum_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   total_value_q;

	logic in_acc, out_free;
	logic item_we, box_we;
	logic [2*AB-1:0] item_rd;
	logic [AB-1:0]   cap_rd;
	logic [CW-1:0]   lim;
	logic            issue, scan_end;
	logic            lt_a_b;
	logic [AB-1:0]   cmp_a, cmp_b;
	logic            take;
	logic [MAX_BOXES-1:0] init_done;
	logic [CW-1:0]   nitems_d;

	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign total_value = total_value_q;

	// Table writes happen only from an accepted load word.
	assign item_we = in_acc && (mode == MODE_LOAD_ITEM) && (int'(item_slot) < MAX_ITEMS);
	assign box_we  = in_acc && (mode == MODE_LOAD_BOX) && (box_slot != '0)
		&& (int'(box_slot) <= MAX_BOXES);

	gca_ram #(.WIDTH(2*AB), .DEPTH(MAX_ITEMS), .AW(IA)) u_item_ram (
		.clk    (clk),
		.we     (item_we),
		.waddr  (IA'(item_slot)),
		.wdata  ({item_weight_in, item_value_in}),
		.raddr  (cnt_q[IA-1:0]),
		.rdata_q(item_rd)
	);

	gca_ram #(.WIDTH(AB), .DEPTH(MAX_BOXES), .AW(BA)) u_cap_ram (
		.clk    (clk),
		.we     (box_we),
		.waddr  (BA'(box_slot - BSLOT_W'(1))),
		.wdata  (box_capacity_in),
		.raddr  (cnt_q[BA-1:0]),
		.rdata_q(cap_rd)
	);

	// Clamp the item count and build the closed-box mask for a new query.
	always_comb begin
		nitems_d = (int'(item_count_q) > MAX_ITEMS) ? CW'(MAX_ITEMS) : CW'(item_count_q);
		for (int b = 0; b < MAX_BOXES; b++) begin
			init_done[b] = !((b < int'(box_count_q))
				&& (((b + 1) < int'(lo_q)) || ((b + 1) > int'(hi_q))));
		end
	end

	// Shared comparator: capacity search in the box pass, fit test in the item pass.
	always_comb begin
		if (state_q == ST_BSCAN) begin
			cmp_a = cap_rd;
			cmp_b = best_q;
		end else begin
			cmp_a = cap_q;
			cmp_b = item_rd[2*AB-1:AB];
		end
		lt_a_b = (cmp_a < cmp_b);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (mode == MODE_QUERY)) state_d = ST_INIT;
			end
			ST_INIT: state_d = ST_BSCAN;
			ST_BSCAN: begin
				if (scan_end) state_d = found_q ? ST_ISCAN : ST_DONE;
			end
			ST_ISCAN: begin
				if (scan_end) state_d = ST_BSCAN;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		lim = '0;
		take = 1'b0;
		case (state_q)
			ST_BSCAN: begin
				lim  = CW'(MAX_BOXES);
				take = vld_s1 && !box_done_q[idx_s1[BA-1:0]] && (!found_q || lt_a_b);
			end
			ST_ISCAN: begin
				lim  = nitems_q;
				take = vld_s1 && !item_taken_q[idx_s1[IA-1:0]] && !lt_a_b
					&& (!found_q || (best_q < item_rd[AB-1:0]));
			end
			default: begin
				lim  = '0;
				take = 1'b0;
			end
		endcase
		issue    = ((state_q == ST_BSCAN) || (state_q == ST_ISCAN)) && (cnt_q < lim);
		scan_end = ((state_q == ST_BSCAN) || (state_q == ST_ISCAN)) && !(cnt_q < lim)
			&& !vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			item_count_q <= '0;
			box_count_q  <= '0;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			box_done_q   <= '0;
			item_taken_q <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ITEM_COUNT: item_count_q <= cfg_data;
					REG_BOX_COUNT:  box_count_q  <= cfg_data;
					default: ;
				endcase
			end
			// raise the result when the query is done, drop it once taken
			if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			vld_s1 <= issue;
			if (issue) cnt_q <= cnt_q + CW'(1);
			if (take) found_q <= 1'b1;

			case (state_q)
				ST_INIT: begin
					box_done_q   <= init_done;
					item_taken_q <= '0;
					sum_q        <= '0;
					cnt_q        <= '0;
					found_q      <= 1'b0;
				end
				ST_BSCAN: begin
					if (scan_end) begin
						// if a box was found, close it and start the item pass
						cnt_q   <= '0;
						found_q <= 1'b0;
						if (found_q) box_done_q[box_pick_q] <= 1'b1;
					end
				end
				ST_ISCAN: begin
					if (scan_end) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						if (found_q) begin
							item_taken_q[item_pick_q] <= 1'b1;
							sum_q <= sum_q + SUM_W'(best_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lo_q <= exclude_low;
			hi_q <= exclude_high;
		end
		// track the address whose read data arrives next cycle
		if (issue) idx_s1 <= cnt_q;
		if (state_q == ST_INIT) nitems_q <= nitems_d;
		if (take) begin
			if (state_q == ST_BSCAN) begin
				best_q     <= cap_rd;
				box_pick_q <= idx_s1[BA-1:0];
			end else begin
				best_q      <= item_rd[AB-1:0];
				item_pick_q <= idx_s1[IA-1:0];
			end
		end
		if ((state_q == ST_BSCAN) && scan_end) cap_q <= best_q;
		if ((state_q == ST_DONE) && out_free) total_value_q <= sum_q[OUT_W-1:0];
	end

`include "greedy_capacity_assignment_unit_assert.svh"

	`ASSERT_AT(a_query_starts, (in_acc && (mode == MODE_QUERY)) |=> (state_q == ST_INIT), "query word did not start a query")
	`ASSERT_AT(a_result_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result raised outside the done step")
	`ASSERT_AT(a_box_closed, ((state_q == ST_ISCAN) && ($past(state_q) == ST_BSCAN)) |-> box_done_q[box_pick_q], "item pass began with chosen box still open")
	`ASSERT_NEVER(a_no_issue_idle, issue && (state_q == ST_IDLE), "memory scan while idle")
endmodule
`default_nettype wire
